// ===== src/lwf_pkg.sv =====
// ---------------------------------------------------------------------------
// lwf_pkg - shared types and constants for the window fill sequencer
// Field widths, bus command codes and the item/result structs used between
// the input register, the sequencing core and the output register.
// ---------------------------------------------------------------------------
package lwf_pkg;

  // field widths
  localparam int unsigned SideW  = 9;
  localparam int unsigned CoordW = 16;
  localparam int unsigned ColorW = 16;
  localparam int unsigned ByteW  = 8;

  // default for the largest window side plus one
  localparam int unsigned MaxSideDefault = 512;

  // item function codes
  localparam logic FuncStart = 1'b0;
  localparam logic FuncTick  = 1'b1;

  // bus command codes
  localparam logic [ByteW-1:0] CmdColSet   = 8'h2A;
  localparam logic [ByteW-1:0] CmdRowSet   = 8'h2B;
  localparam logic [ByteW-1:0] CmdMemWrite = 8'h2C;
  localparam logic [ByteW-1:0] ByteMask    = 8'hFF;

  // one input item
  typedef struct packed {
    logic              func;
    logic [SideW-1:0]  start_col;
    logic [SideW-1:0]  start_row;
    logic [SideW-1:0]  win_width;
    logic [SideW-1:0]  win_height;
    logic [ColorW-1:0] fill_color;
  } lwf_item_t;

  // one result item
  typedef struct packed {
    logic             is_data;
    logic [ByteW-1:0] bus_byte;
    logic             last;
  } lwf_res_t;

  // handoff from the input register to the core
  typedef struct packed {
    logic      vld;
    lwf_item_t item;
  } lwf_stage_t;

endpackage

// ===== src/lwf_if.sv =====
// ---------------------------------------------------------------------------
// lwf_if - valid/ready channels of the window fill sequencer
// Input channel carries the start/tick item, output channel one bus byte.
// ---------------------------------------------------------------------------
interface lwf_in_if import lwf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [SideW-1:0]  start_col;
  logic [SideW-1:0]  start_row;
  logic [SideW-1:0]  win_width;
  logic [SideW-1:0]  win_height;
  logic [ColorW-1:0] fill_color;

  modport source (
    output valid, func, start_col, start_row, win_width, win_height, fill_color,
    input  ready
  );
  modport sink (
    input  valid, func, start_col, start_row, win_width, win_height, fill_color,
    output ready
  );
endinterface

interface lwf_out_if import lwf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_data;
  logic [ByteW-1:0] bus_byte;
  logic             last;

  modport source (
    output valid, is_data, bus_byte, last,
    input  ready
  );
  modport sink (
    input  valid, is_data, bus_byte, last,
    output ready
  );
endinterface

// ===== src/lwf_in_reg.sv =====
// ---------------------------------------------------------------------------
// lwf_in_reg - input item register
// Holds one accepted item until the core takes it; refills in the same cycle.
// ---------------------------------------------------------------------------
module lwf_in_reg import lwf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  lwf_item_t  item_i,
  input  logic       take_i,
  output lwf_stage_t stage_o
);

  logic      vld_q, vld_d;
  lwf_item_t item_q;
  logic      accept;

  // free when empty or drained this cycle
  assign ready_o = !vld_q || take_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.item = item_q;

endmodule

// ===== src/lwf_seq_core.sv =====
// ---------------------------------------------------------------------------
// lwf_seq_core - window fill sequencing state
// Latches the window on a start item and picks the next bus byte on a tick.
// ---------------------------------------------------------------------------
module lwf_seq_core import lwf_pkg::*; #(
  parameter int unsigned MAX_SIDE = MaxSideDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lwf_stage_t stage_i,
  input  logic       out_free_i,
  output logic       take_o,
  output logic       res_vld_o,
  output lwf_res_t   res_o
);

  // largest side the 9-bit fields can reach after clamping
  localparam int unsigned SideLim = (MAX_SIDE - 1 < (1 << SideW) - 1) ?
                                    MAX_SIDE - 1 : (1 << SideW) - 1;
  localparam int unsigned PixW    = $clog2(SideLim * SideLim + 1);
  localparam logic [SideW-1:0] SideMax = SideW'(SideLim);

  typedef enum logic [3:0] {
    StepColCmd     = 4'd0,
    StepColBeginHi = 4'd1,
    StepColBeginLo = 4'd2,
    StepColEndHi   = 4'd3,
    StepColEndLo   = 4'd4,
    StepRowCmd     = 4'd5,
    StepRowBeginHi = 4'd6,
    StepRowBeginLo = 4'd7,
    StepRowEndHi   = 4'd8,
    StepRowEndLo   = 4'd9,
    StepMemCmd     = 4'd10,
    StepPixels     = 4'd11
  } hdr_step_e;

  logic              busy_q, busy_d;
  hdr_step_e         step_q, step_d;
  logic [PixW-1:0]   pix_q, pix_d;
  logic              low_q, low_d;
  logic [SideW-1:0]  col_begin_q, row_begin_q;
  logic [CoordW-1:0] col_end_q, row_end_q;
  logic [ColorW-1:0] color_q;
  logic              latch;

  logic [SideW-1:0]    w_cl, h_cl;
  logic [CoordW-1:0]   col_end_d, row_end_d;
  logic [2*SideW-1:0]  area;
  logic [PixW-1:0]     pix_dec;
  lwf_item_t           item;

  assign item   = stage_i.item;
  assign take_o = stage_i.vld && out_free_i;

  // clamp sizes, window end corners and pixel count
  assign w_cl      = (item.win_width  > SideMax) ? SideMax : item.win_width;
  assign h_cl      = (item.win_height > SideMax) ? SideMax : item.win_height;
  assign col_end_d = CoordW'(item.start_col) + CoordW'(w_cl) - CoordW'(1);
  assign row_end_d = CoordW'(item.start_row) + CoordW'(h_cl) - CoordW'(1);
  assign area      = w_cl * h_cl;
  assign pix_dec   = pix_q - PixW'(1);

  // next state and result byte
  always_comb begin
    busy_d        = busy_q;
    step_d        = step_q;
    pix_d         = pix_q;
    low_d         = low_q;
    latch         = 1'b0;
    res_vld_o     = 1'b0;
    res_o.is_data = 1'b1;
    res_o.bus_byte = '0;
    res_o.last    = 1'b0;
    if (take_o) begin
      if (item.func == FuncStart) begin
        if (!busy_q) begin
          latch  = 1'b1;
          busy_d = 1'b1;
          step_d = StepColCmd;
          low_d  = 1'b0;
          pix_d  = PixW'(area);
        end
      end else if (busy_q) begin
        res_vld_o = 1'b1;
        if (step_q != StepPixels) begin
          step_d = hdr_step_e'(step_q + 4'd1);
          unique case (step_q)
            StepColCmd: begin
              res_o.is_data  = 1'b0;
              res_o.bus_byte = CmdColSet;
            end
            StepColBeginHi: res_o.bus_byte = ByteW'(col_begin_q >> ByteW);
            StepColBeginLo: res_o.bus_byte = col_begin_q[ByteW-1:0];
            StepColEndHi:   res_o.bus_byte = col_end_q[CoordW-1:ByteW];
            StepColEndLo:   res_o.bus_byte = col_end_q[ByteW-1:0];
            StepRowCmd: begin
              res_o.is_data  = 1'b0;
              res_o.bus_byte = CmdRowSet;
            end
            StepRowBeginHi: res_o.bus_byte = ByteW'(row_begin_q >> ByteW);
            StepRowBeginLo: res_o.bus_byte = row_begin_q[ByteW-1:0];
            StepRowEndHi:   res_o.bus_byte = row_end_q[CoordW-1:ByteW];
            StepRowEndLo:   res_o.bus_byte = row_end_q[ByteW-1:0];
            StepMemCmd: begin
              res_o.is_data  = 1'b0;
              res_o.bus_byte = CmdMemWrite;
              // empty window ends on the memory write command
              if (pix_q == '0) begin
                res_o.last = 1'b1;
                busy_d     = 1'b0;
              end
            end
            default: begin
              res_o.bus_byte = ByteMask;
            end
          endcase
        end else if (!low_q) begin
          res_o.bus_byte = color_q[ColorW-1:ByteW];
          low_d          = 1'b1;
        end else begin
          res_o.bus_byte = color_q[ByteW-1:0];
          low_d          = 1'b0;
          if (pix_q != '0) begin
            pix_d = pix_dec;
          end
          if (pix_q == PixW'(1) || pix_q == '0) begin
            res_o.last = 1'b1;
            busy_d     = 1'b0;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StepColCmd;
      pix_q  <= '0;
      low_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      pix_q  <= pix_d;
      low_q  <= low_d;
    end
  end

  // window and color latch
  always_ff @(posedge clk_i) begin
    if (latch) begin
      col_begin_q <= item.start_col;
      row_begin_q <= item.start_row;
      col_end_q   <= col_end_d;
      row_end_q   <= row_end_d;
      color_q     <= item.fill_color;
    end
  end

endmodule

// ===== src/lwf_out_reg.sv =====
// ---------------------------------------------------------------------------
// lwf_out_reg - result item register
// Holds one bus byte until the receiver takes it.
// ---------------------------------------------------------------------------
module lwf_out_reg import lwf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_vld_i,
  input  lwf_res_t res_i,
  output logic     free_o,
  output logic     valid_o,
  input  logic     ready_i,
  output lwf_res_t res_o
);

  logic     vld_q, vld_d;
  lwf_res_t res_q;

  // can load when empty or being drained
  assign free_o = !vld_q || ready_i;

  always_comb begin
    vld_d = vld_q;
    if (res_vld_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

// ===== src/lcd_window_fill_sequencer.sv =====
// ---------------------------------------------------------------------------
// lcd_window_fill_sequencer - rectangle fill byte source for a DCS LCD bus
// Turns a start item plus a stream of tick items into the command/data
// bytes that set a column/row window and fill it with one color.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  : valid/ready items. func=0 starts a fill (ignored while a fill is
//           running), func=1 asks for the next bus byte (ignored when idle).
//   out_o : valid/ready bus bytes with is_data and last. Header is 0x2A with
//           four column bytes, 0x2B with four row bytes, 0x2C, then color
//           high/low per pixel; last marks the final byte of a fill.
//   Path: a tick is held in the input register, its byte in the output register.
//   Throughput: one item per cycle while out_o is not stalled; the sequencing
//           step between the input register and the output register is combinational.
//   Stall: while out_o is held, the output register keeps its byte, the
//           input register holds one more item and in_i.ready drops.
//   Reset: rst_ni clears both registers and the sequencer to idle.
// ---------------------------------------------------------------------------
module lcd_window_fill_sequencer import lwf_pkg::*; #(
  parameter int unsigned MAX_SIDE = MaxSideDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lwf_in_if.sink    in_i,
  lwf_out_if.source out_o
);

  lwf_item_t  in_item;
  lwf_stage_t stage;
  logic       take;
  logic       out_free;
  logic       res_vld;
  lwf_res_t   res;
  lwf_res_t   out_res;

  // input payload gather
  assign in_item.func       = in_i.func;
  assign in_item.start_col  = in_i.start_col;
  assign in_item.start_row  = in_i.start_row;
  assign in_item.win_width  = in_i.win_width;
  assign in_item.win_height = in_i.win_height;
  assign in_item.fill_color = in_i.fill_color;

  lwf_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .take_i  (take),
    .stage_o (stage)
  );

  lwf_seq_core #(
    .MAX_SIDE (MAX_SIDE)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (stage),
    .out_free_i (out_free),
    .take_o     (take),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  lwf_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_vld_i (res_vld),
    .res_i     (res),
    .free_o    (out_free),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .res_o     (out_res)
  );

  // output payload scatter
  assign out_o.is_data  = out_res.is_data;
  assign out_o.bus_byte = out_res.bus_byte;
  assign out_o.last     = out_res.last;

endmodule

// ===== tb/lwf_fill_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lwf_fill_checker - bus byte predictor and scoreboard for the fill sequencer
// Watches both channels, predicts the byte that each accepted tick gives and
// compares every accepted bus byte, field by field, with the oldest one due.
// ---------------------------------------------------------------------------
module lwf_fill_checker import lwf_pkg::*; #(
  parameter int unsigned MAX_SIDE = MaxSideDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lwf_in_if           in_mon,
  lwf_out_if          out_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pend_cnt_o
);

  // position in the window header, pixel phase after the memory write command
  typedef enum logic [3:0] {
    StColCmd, StColBegHi, StColBegLo, StColEndHi, StColEndLo,
    StRowCmd, StRowBegHi, StRowBegLo, StRowEndHi, StRowEndLo,
    StMemCmd, StPixels
  } hdr_step_e;

  // predicted sequencer state
  logic              busy;
  hdr_step_e         step;
  logic [17:0]       pix_left;
  logic              low_next;
  logic [CoordW-1:0] col_beg;
  logic [CoordW-1:0] col_end;
  logic [CoordW-1:0] row_beg;
  logic [CoordW-1:0] row_end;
  logic [ColorW-1:0] color;

  // bus bytes predicted but not yet seen
  lwf_res_t exp_bytes_q[$];

  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] s);
    if (s > MAX_SIDE - 1) return SideW'(MAX_SIDE - 1);
    return s;
  endfunction

  // advance the predicted state by one item, returns 1 when a byte is due
  function automatic bit next_bus_byte(input lwf_item_t item, output lwf_res_t res);
    logic [SideW-1:0] w;
    logic [SideW-1:0] h;
    res.is_data  = 1'b1;
    res.bus_byte = '0;
    res.last     = 1'b0;
    // start latches the window only when idle
    if (item.func == FuncStart) begin
      if (!busy) begin
        w        = clamp_side(item.win_width);
        h        = clamp_side(item.win_height);
        col_beg  = CoordW'(item.start_col);
        col_end  = CoordW'(item.start_col) + CoordW'(w) - CoordW'(1);
        row_beg  = CoordW'(item.start_row);
        row_end  = CoordW'(item.start_row) + CoordW'(h) - CoordW'(1);
        color    = item.fill_color;
        pix_left = 18'(w) * 18'(h);
        step     = StColCmd;
        low_next = 1'b0;
        busy     = 1'b1;
      end
      return 1'b0;
    end
    if (!busy) return 1'b0;
    // header bytes
    if (step != StPixels) begin
      case (step)
        StColCmd: begin
          res.is_data  = 1'b0;
          res.bus_byte = CmdColSet;
        end
        StColBegHi: res.bus_byte = col_beg[15:8];
        StColBegLo: res.bus_byte = col_beg[7:0];
        StColEndHi: res.bus_byte = col_end[15:8];
        StColEndLo: res.bus_byte = col_end[7:0];
        StRowCmd: begin
          res.is_data  = 1'b0;
          res.bus_byte = CmdRowSet;
        end
        StRowBegHi: res.bus_byte = row_beg[15:8];
        StRowBegLo: res.bus_byte = row_beg[7:0];
        StRowEndHi: res.bus_byte = row_end[15:8];
        StRowEndLo: res.bus_byte = row_end[7:0];
        default: begin
          res.is_data  = 1'b0;
          res.bus_byte = CmdMemWrite;
          // empty window ends on the memory write command
          if (pix_left == '0) begin
            res.last = 1'b1;
            busy     = 1'b0;
          end
        end
      endcase
      step = hdr_step_e'(step + 4'd1);
    end else if (!low_next) begin
      res.bus_byte = color[15:8];
      low_next     = 1'b1;
    end else begin
      res.bus_byte = color[7:0];
      low_next     = 1'b0;
      if (pix_left != '0) pix_left = pix_left - 18'd1;
      if (pix_left == '0) begin
        res.last = 1'b1;
        busy     = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // compare on the output side, then predict from the input side
  always @(posedge clk_i or negedge rst_ni) begin
    lwf_item_t item_in;
    lwf_res_t  want;
    lwf_res_t  got;
    if (!rst_ni) begin
      busy       = 1'b0;
      step       = StColCmd;
      pix_left   = '0;
      low_next   = 1'b0;
      col_beg    = '0;
      col_end    = '0;
      row_beg    = '0;
      row_end    = '0;
      color      = '0;
      exp_bytes_q.delete();
      fail_cnt_o = 0;
      pend_cnt_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.is_data  = out_mon.is_data;
        got.bus_byte = out_mon.bus_byte;
        got.last     = out_mon.last;
        if (exp_bytes_q.size() == 0) begin
          $display("%0t: unexpected bus byte, expected none, actual %h/%h/%h",
                   $time, got.is_data, got.bus_byte, got.last);
          fail_cnt_o++;
        end else begin
          want = exp_bytes_q.pop_front();
          if (got.is_data !== want.is_data) begin
            $display("%0t: is_data mismatch, expected %h, actual %h",
                     $time, want.is_data, got.is_data);
            fail_cnt_o++;
          end
          if (got.bus_byte !== want.bus_byte) begin
            $display("%0t: bus_byte mismatch, expected %h, actual %h",
                     $time, want.bus_byte, got.bus_byte);
            fail_cnt_o++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last mismatch, expected %h, actual %h",
                     $time, want.last, got.last);
            fail_cnt_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        item_in.func       = in_mon.func;
        item_in.start_col  = in_mon.start_col;
        item_in.start_row  = in_mon.start_row;
        item_in.win_width  = in_mon.win_width;
        item_in.win_height = in_mon.win_height;
        item_in.fill_color = in_mon.fill_color;
        if (next_bus_byte(item_in, want)) exp_bytes_q.push_back(want);
      end
      pend_cnt_o = exp_bytes_q.size();
    end
  end

endmodule

// ===== tb/lcd_window_fill_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lcd_window_fill_sequencer_tb - testbench top for the window fill sequencer
// Drives start and tick items with random gaps and output stalls, including
// one long output hold-off; the checker predicts and compares every byte.
// ---------------------------------------------------------------------------
module lcd_window_fill_sequencer_tb;
  import lwf_pkg::*;

  localparam int unsigned NumItems   = 1100;
  localparam int unsigned CalmItems  = 950;
  localparam int unsigned LongStall  = 60;
  localparam int unsigned HeaderLen  = 11;
  localparam int unsigned DrainWait  = 20;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pend_cnt;
  int unsigned sent_cnt;
  bit          calm;
  bit          long_stall_go;
  bit          long_stall_done;

  lwf_in_if  in_if ();
  lwf_out_if out_if ();

  lcd_window_fill_sequencer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  lwf_fill_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pend_cnt_o (pend_cnt)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // random item, every field random except the function
  function automatic lwf_item_t rand_item(input logic f);
    lwf_item_t item;
    item.func       = f;
    item.start_col  = SideW'($urandom);
    item.start_row  = SideW'($urandom);
    item.win_width  = SideW'($urandom);
    item.win_height = SideW'($urandom);
    item.fill_color = ColorW'($urandom);
    return item;
  endfunction

  // offer one item until accepted, then maybe leave a gap
  task automatic send_item(input lwf_item_t item);
    int unsigned k;
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.func       <= item.func;
    in_if.start_col  <= item.start_col;
    in_if.start_row  <= item.start_row;
    in_if.win_width  <= item.win_width;
    in_if.win_height <= item.win_height;
    in_if.fill_color <= item.fill_color;
    do @(posedge clk_i); while (!in_if.ready);
    sent_cnt++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      k = $urandom_range(1, 5);
      repeat (k) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
    end
  endtask

  // start a fill and tick through it, with optional noise
  task automatic run_fill(input lwf_item_t start, input bit noisy);
    int unsigned n;
    send_item(start);
    n = HeaderLen + 2 * int'(start.win_width) * int'(start.win_height);
    // broken sequence: stop ticking early, the fill stays open
    if (noisy && $urandom_range(0, 11) == 0) n = $urandom_range(1, n - 1);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(rand_item(FuncTick));
      // start while busy is dropped by the block
      if (noisy && $urandom_range(0, 19) == 0) send_item(rand_item(FuncStart));
    end
  endtask

  // receiver: random stalls, one long hold-off, none at the end
  initial begin
    int unsigned k;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_stall_go && !long_stall_done) begin
        long_stall_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LongStall - 1) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        k = $urandom_range(1, 5);
        repeat (k - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    lwf_item_t   item;
    int unsigned fill_no;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = FuncTick;
    in_if.start_col  = '0;
    in_if.start_row  = '0;
    in_if.win_width  = '0;
    in_if.win_height = '0;
    in_if.fill_color = '0;
    sent_cnt         = 0;
    calm             = 1'b0;
    long_stall_go    = 1'b0;
    long_stall_done  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: tick while idle gives nothing
    send_item(rand_item(FuncTick));
    // empty window at the origin, end coordinates wrap to all ones
    item = '{func: FuncStart, start_col: '0, start_row: '0, win_width: '0,
             win_height: '0, fill_color: '0};
    send_item(item);
    // start while busy with every field at its top value
    item = '{func: FuncStart, start_col: '1, start_row: '1, win_width: '1,
             win_height: '1, fill_color: '1};
    send_item(item);
    for (int unsigned i = 0; i < HeaderLen; i++) send_item(rand_item(FuncTick));
    // single pixel in the far corner
    item = '{func: FuncStart, start_col: '1, start_row: '1, win_width: 9'd1,
             win_height: 9'd1, fill_color: '1};
    run_fill(item, 1'b0);

    // random fills, the first with one side at the large end
    fill_no = 0;
    while (sent_cnt < NumItems) begin
      item = rand_item(FuncStart);
      item.win_width  = SideW'($urandom_range(0, 4));
      item.win_height = SideW'($urandom_range(0, 4));
      if (fill_no == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          item.win_width  = SideW'($urandom_range(256, 300));
          item.win_height = 9'd1;
        end else begin
          item.win_width  = 9'd1;
          item.win_height = SideW'($urandom_range(256, 300));
        end
      end else if (fill_no == 1) begin
        long_stall_go = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) send_item(rand_item(FuncTick));
      run_fill(item, fill_no > 0);
      if (sent_cnt >= CalmItems) calm = 1'b1;
      fill_no++;
    end

    // drain
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
